### rtl/core/ipsc_pkg.sv
// shared types, codes and reset constants for the inactivity power-state controller
`timescale 1ns / 1ps
package ipsc_pkg;

  // stored power state, one-hot
  typedef enum logic [2:0] {
    PWR_RUN  = 3'b001,
    PWR_IDLE = 3'b010,
    PWR_LOW  = 3'b100
  } pwr_t;

  // power state codes on the result word
  localparam logic [1:0] PS_RUN  = 2'd0;
  localparam logic [1:0] PS_IDLE = 2'd1;
  localparam logic [1:0] PS_LOW  = 2'd2;
  localparam logic [1:0] PS_WAKE = 2'd3;

  // governor codes
  localparam logic [1:0] GOV_NONE     = 2'd0;
  localparam logic [1:0] GOV_PERF     = 2'd1;
  localparam logic [1:0] GOV_ONDEMAND = 2'd2;

  // register indexes
  localparam logic [2:0] REG_IDLE_AFTER = 3'd0;
  localparam logic [2:0] REG_LOW_AFTER  = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd2;
  localparam logic [2:0] REG_PERIOD     = 3'd3;
  localparam logic [2:0] REG_RUN_LED    = 3'd4;
  localparam logic [2:0] REG_IDLE_LED   = 3'd5;
  localparam logic [2:0] REG_LOW_LED    = 3'd6;

  localparam int unsigned CFG_ADDR_W = 5;

  // register reset values
  localparam logic [15:0] RST_IDLE_AFTER = 16'd5000;
  localparam logic [15:0] RST_LOW_AFTER  = 16'd10000;
  localparam logic [9:0]  RST_DEBOUNCE   = 10'd200;
  localparam logic [11:0] RST_PERIOD     = 12'd1000;
  localparam logic [6:0]  RST_RUN_LED    = 7'd100;
  localparam logic [6:0]  RST_IDLE_LED   = 7'd40;
  localparam logic [6:0]  RST_LOW_LED    = 7'd10;

  localparam logic [6:0]  PCT_MAX        = 7'd100;

  // one result word
  typedef struct packed {
    logic [1:0] power_state;
    logic [6:0] led_percent;
    logic       led_on;
    logic [1:0] governor_action;
    logic       announce;
    logic       rx_pop;
    logic       last;
  } result_t;

  // limit a brightness register to one hundred percent
  function automatic logic [6:0] clamp_pct(input logic [6:0] p);
    return (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

  // build a result word
  function automatic result_t mk_result(input logic [1:0] st, input logic [6:0] pct,
                                        input logic [1:0] gov, input logic ann,
                                        input logic pop, input logic lst);
    result_t r;
    r.power_state     = st;
    r.led_percent     = pct;
    r.led_on          = (pct != 7'd0);
    r.governor_action = gov;
    r.announce        = ann;
    r.rx_pop          = pop;
    r.last            = lst;
    return r;
  endfunction

endpackage

### rtl/core/ipsc_if.sv
// valid/ready channel interfaces for input events and result words
`timescale 1ns / 1ps
interface ipsc_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic rx_nonempty;

  modport source (output valid, mode, rx_nonempty, input ready);
  modport sink   (input valid, mode, rx_nonempty, output ready);
endinterface

interface ipsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] power_state;
  logic [6:0] led_percent;
  logic       led_on;
  logic [1:0] governor_action;
  logic       announce;
  logic       rx_pop;
  logic       last;

  modport source (output valid, power_state, led_percent, led_on, governor_action,
                  announce, rx_pop, last, input ready);
  modport sink   (input valid, power_state, led_percent, led_on, governor_action,
                  announce, rx_pop, last, output ready);
endinterface

### rtl/core/inactivity_power_state_controller.sv
// inactivity power-state controller: idle timing, key debounce and state reporting
// A result word is registered into the result queue and presented from its head.
// Throughput: one event word per cycle while ready is high; ready stays high while fewer
// than two result words are queued in the three-entry result queue. Reset (synchronous,
// rst_n low) clears counters, sets key age to saturation, state to running, registers
// to defaults and empties the queue.
`timescale 1ns / 1ps
module inactivity_power_state_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  ipsc_in_if.sink                           in_ch,
  ipsc_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // configuration registers
  logic [15:0] idle_after_r;
  logic [15:0] low_after_r;
  logic [9:0]  debounce_r;
  logic [11:0] period_cfg_r;
  logic [6:0]  run_led_r;
  logic [6:0]  idle_led_r;
  logic [6:0]  low_led_r;

  // controller state
  logic [15:0]      idle_ms_r, idle_ms_nxt;
  logic [9:0]       key_age_r, key_age_nxt;
  logic [11:0]      period_r, period_nxt;
  ipsc_pkg::pwr_t   pwr_r, pwr_nxt;

  // result queue
  ipsc_pkg::result_t q_r [3];
  ipsc_pkg::result_t q_nxt [3];
  logic [1:0]        cnt_r, cnt_nxt;

  logic              in_acc;
  logic              out_pop;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic [15:0]       idle_inc;
  logic [9:0]        key_inc;
  logic              check;
  logic [6:0]        run_pct, idle_pct, low_pct;
  ipsc_pkg::pwr_t    want;
  logic [1:0]        want_code, cur_code;
  logic [6:0]        want_pct, cur_pct;
  logic [1:0]        want_gov;
  ipsc_pkg::result_t res0, res1;
  logic [1:0]        n_res;
  logic [1:0]        base;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_after_r <= ipsc_pkg::RST_IDLE_AFTER;
      low_after_r  <= ipsc_pkg::RST_LOW_AFTER;
      debounce_r   <= ipsc_pkg::RST_DEBOUNCE;
      period_cfg_r <= ipsc_pkg::RST_PERIOD;
      run_led_r    <= ipsc_pkg::RST_RUN_LED;
      idle_led_r   <= ipsc_pkg::RST_IDLE_LED;
      low_led_r    <= ipsc_pkg::RST_LOW_LED;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ipsc_pkg::REG_IDLE_AFTER: idle_after_r <= pwdata[15:0];
        ipsc_pkg::REG_LOW_AFTER:  low_after_r  <= pwdata[15:0];
        ipsc_pkg::REG_DEBOUNCE:   debounce_r   <= pwdata[9:0];
        ipsc_pkg::REG_PERIOD:     period_cfg_r <= pwdata[11:0];
        ipsc_pkg::REG_RUN_LED:    run_led_r    <= pwdata[6:0];
        ipsc_pkg::REG_IDLE_LED:   idle_led_r   <= pwdata[6:0];
        ipsc_pkg::REG_LOW_LED:    low_led_r    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      ipsc_pkg::REG_IDLE_AFTER: prdata = {16'd0, idle_after_r};
      ipsc_pkg::REG_LOW_AFTER:  prdata = {16'd0, low_after_r};
      ipsc_pkg::REG_DEBOUNCE:   prdata = {22'd0, debounce_r};
      ipsc_pkg::REG_PERIOD:     prdata = {20'd0, period_cfg_r};
      ipsc_pkg::REG_RUN_LED:    prdata = {25'd0, run_led_r};
      ipsc_pkg::REG_IDLE_LED:   prdata = {25'd0, idle_led_r};
      ipsc_pkg::REG_LOW_LED:    prdata = {25'd0, low_led_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // handshakes
  assign in_ch.ready = (cnt_r < 2'd2);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_pop     = out_ch.valid && out_ch.ready;

  // saturating counters and period check
  assign idle_inc = (idle_ms_r == 16'hFFFF) ? idle_ms_r : idle_ms_r + 16'd1;
  assign key_inc  = (key_age_r == 10'h3FF) ? key_age_r : key_age_r + 10'd1;
  assign check    = ({1'b0, period_r} + 13'd1) >= {1'b0, period_cfg_r};

  // clamped brightness values
  assign run_pct  = ipsc_pkg::clamp_pct(run_led_r);
  assign idle_pct = ipsc_pkg::clamp_pct(idle_led_r);
  assign low_pct  = ipsc_pkg::clamp_pct(low_led_r);

  // target state from idle time after this tick
  always_comb begin
    if (idle_inc > low_after_r) begin
      want = ipsc_pkg::PWR_LOW;
    end else if (idle_inc > idle_after_r) begin
      want = ipsc_pkg::PWR_IDLE;
    end else begin
      want = ipsc_pkg::PWR_RUN;
    end
  end

  // codes, brightness and governor for target and current state
  always_comb begin
    case (want)
      ipsc_pkg::PWR_LOW: begin
        want_code = ipsc_pkg::PS_LOW;
        want_pct  = low_pct;
        want_gov  = ipsc_pkg::GOV_ONDEMAND;
      end
      ipsc_pkg::PWR_IDLE: begin
        want_code = ipsc_pkg::PS_IDLE;
        want_pct  = idle_pct;
        want_gov  = ipsc_pkg::GOV_NONE;
      end
      default: begin
        want_code = ipsc_pkg::PS_RUN;
        want_pct  = run_pct;
        want_gov  = ipsc_pkg::GOV_PERF;
      end
    endcase
    case (pwr_r)
      ipsc_pkg::PWR_LOW: begin
        cur_code = ipsc_pkg::PS_LOW;
        cur_pct  = low_pct;
      end
      ipsc_pkg::PWR_IDLE: begin
        cur_code = ipsc_pkg::PS_IDLE;
        cur_pct  = idle_pct;
      end
      default: begin
        cur_code = ipsc_pkg::PS_RUN;
        cur_pct  = run_pct;
      end
    endcase
  end

  // event processing
  always_comb begin
    idle_ms_nxt = idle_ms_r;
    key_age_nxt = key_age_r;
    period_nxt  = period_r;
    pwr_nxt     = pwr_r;
    n_res       = 2'd0;
    res0        = '0;
    res1        = '0;
    if (in_acc) begin
      if (in_ch.mode) begin
        // key press, debounced against key age
        if (key_age_r >= debounce_r) begin
          key_age_nxt = 10'd0;
          idle_ms_nxt = 16'd0;
          if (pwr_r != ipsc_pkg::PWR_RUN) begin
            res0    = ipsc_pkg::mk_result(ipsc_pkg::PS_WAKE, run_pct, ipsc_pkg::GOV_PERF,
                                          1'b1, 1'b0, 1'b0);
            res1    = ipsc_pkg::mk_result(ipsc_pkg::PS_RUN, run_pct, ipsc_pkg::GOV_NONE,
                                          1'b1, 1'b0, 1'b1);
            n_res   = 2'd2;
            pwr_nxt = ipsc_pkg::PWR_RUN;
          end
        end
      end else begin
        // millisecond tick
        idle_ms_nxt = idle_inc;
        key_age_nxt = key_inc;
        if (!check) begin
          period_nxt = period_r + 12'd1;
        end else begin
          period_nxt = 12'd0;
          if (in_ch.rx_nonempty) begin
            // receive byte counts as activity, state ends up running
            idle_ms_nxt = 16'd0;
            pwr_nxt     = ipsc_pkg::PWR_RUN;
            if (pwr_r != ipsc_pkg::PWR_RUN) begin
              res0  = ipsc_pkg::mk_result(ipsc_pkg::PS_WAKE, run_pct, ipsc_pkg::GOV_PERF,
                                          1'b1, 1'b1, 1'b0);
              res1  = ipsc_pkg::mk_result(ipsc_pkg::PS_RUN, run_pct, ipsc_pkg::GOV_NONE,
                                          1'b1, 1'b0, 1'b1);
              n_res = 2'd2;
            end else begin
              res0  = ipsc_pkg::mk_result(ipsc_pkg::PS_RUN, run_pct, ipsc_pkg::GOV_NONE,
                                          1'b0, 1'b1, 1'b1);
              n_res = 2'd1;
            end
          end else if (want != pwr_r) begin
            // state change announcement
            res0    = ipsc_pkg::mk_result(want_code, want_pct, want_gov, 1'b1, 1'b0, 1'b1);
            n_res   = 2'd1;
            pwr_nxt = want;
          end else begin
            // plain status word
            res0  = ipsc_pkg::mk_result(cur_code, cur_pct, ipsc_pkg::GOV_NONE,
                                        1'b0, 1'b0, 1'b1);
            n_res = 2'd1;
          end
        end
      end
    end
  end

  // result queue: shift on pop, append new words behind the survivors
  always_comb begin
    base = cnt_r - {1'b0, out_pop};
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (out_pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
    end
    if (n_res != 2'd0) begin
      q_nxt[base] = res0;
    end
    if (n_res == 2'd2) begin
      q_nxt[base + 2'd1] = res1;
    end
    cnt_nxt = base + n_res;
  end

  // state and queue registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ms_r <= 16'd0;
      key_age_r <= 10'h3FF;
      period_r  <= 12'd0;
      pwr_r     <= ipsc_pkg::PWR_RUN;
      cnt_r     <= 2'd0;
    end else begin
      idle_ms_r <= idle_ms_nxt;
      key_age_r <= key_age_nxt;
      period_r  <= period_nxt;
      pwr_r     <= pwr_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // result channel
  assign out_ch.valid           = (cnt_r != 2'd0);
  assign out_ch.power_state     = q_r[0].power_state;
  assign out_ch.led_percent     = q_r[0].led_percent;
  assign out_ch.led_on          = q_r[0].led_on;
  assign out_ch.governor_action = q_r[0].governor_action;
  assign out_ch.announce        = q_r[0].announce;
  assign out_ch.rx_pop          = q_r[0].rx_pop;
  assign out_ch.last            = q_r[0].last;

  // a wakeup word never ends an event
  a_wake_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.power_state == ipsc_pkg::PS_WAKE |-> !out_ch.last)
    else $error("wakeup word marked last");

  // a taken wakeup word is followed by a running announcement
  a_wake_then_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && out_ch.power_state == ipsc_pkg::PS_WAKE |=>
      out_ch.valid && out_ch.power_state == ipsc_pkg::PS_RUN && out_ch.announce)
    else $error("wakeup word not followed by running word");

  // the stored state is running after any word that pops a receive byte
  a_pop_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.mode && check && in_ch.rx_nonempty |=> pwr_r == ipsc_pkg::PWR_RUN)
    else $error("state not running after receive activity");

  // brightness stays within range and matches the enable
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.led_percent <= ipsc_pkg::PCT_MAX &&
      out_ch.led_on == (out_ch.led_percent != 7'd0))
    else $error("led word out of range");

endmodule

### tb/tb.sv
// self-checking testbench for the inactivity power-state controller
`timescale 1ns / 1ps
module tb;

  localparam logic MODE_TICK     = 1'b0;
  localparam logic MODE_KEY      = 1'b1;
  localparam int   HOLD_CYCLES   = 80;
  localparam int   REPORT_LIMIT  = 10;
  localparam int   SETTLE_CYCLES = 4;
  localparam int   PHASES        = 11;
  localparam int   PHASE_WORDS   = 99;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  // one row of the directed table; n_typed < 0 means the predictor decides
  typedef struct {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [31:0]       data;
    logic              m;
    logic              rx;
    int                n_typed;
    ipsc_pkg::result_t w0;
    ipsc_pkg::result_t w1;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ipsc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  ipsc_in_if  in_ch();
  ipsc_out_if out_ch();

  inactivity_power_state_controller u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the registers
  logic [15:0] lim_idle;
  logic [15:0] lim_low;
  logic [9:0]  debounce_len;
  logic [11:0] period_len;
  logic [6:0]  led_run;
  logic [6:0]  led_idle;
  logic [6:0]  led_low;

  // predictor copy of the state
  logic [15:0] idle_time;
  logic [9:0]  key_age;
  logic [11:0] period_pos;
  logic [1:0]  power_now;

  ipsc_pkg::result_t pred_words[2];
  ipsc_pkg::result_t expected_words[$];
  plan_row_t         directed_rows[$];

  // typed expectation for the word being offered
  int                typed_n;
  ipsc_pkg::result_t typed_w0;
  ipsc_pkg::result_t typed_w1;

  int                mismatches = 0;
  int                produced;
  ipsc_pkg::result_t got;
  ipsc_pkg::result_t want;

  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_asked  = 0;
  int hold_served;
  int hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic ipsc_pkg::result_t pack_word(input logic [1:0] st,
                                                  input logic [6:0] pct,
                                                  input logic [1:0] gov, input logic ann,
                                                  input logic pop, input logic lst);
    ipsc_pkg::result_t w;
    w.power_state     = st;
    w.led_percent     = pct;
    w.led_on          = (pct != 7'd0);
    w.governor_action = gov;
    w.announce        = ann;
    w.rx_pop          = pop;
    w.last            = lst;
    return w;
  endfunction

  // brightness for a reported state, limited to one hundred
  function automatic ipsc_pkg::result_t state_word(input logic [1:0] st,
                                                   input logic [1:0] gov,
                                                   input logic ann, input logic pop);
    logic [6:0] pct;
    if (st == ipsc_pkg::PS_IDLE) pct = led_idle;
    else if (st == ipsc_pkg::PS_LOW) pct = led_low;
    else pct = led_run;
    if (pct > 7'd100) pct = 7'd100;
    return pack_word(st, pct, gov, ann, pop, 1'b0);
  endfunction

  function automatic void set_register(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      ipsc_pkg::REG_IDLE_AFTER: lim_idle     = v[15:0];
      ipsc_pkg::REG_LOW_AFTER:  lim_low      = v[15:0];
      ipsc_pkg::REG_DEBOUNCE:   debounce_len = v[9:0];
      ipsc_pkg::REG_PERIOD:     period_len   = v[11:0];
      ipsc_pkg::REG_RUN_LED:    led_run      = v[6:0];
      ipsc_pkg::REG_IDLE_LED:   led_idle     = v[6:0];
      ipsc_pkg::REG_LOW_LED:    led_low      = v[6:0];
      default: ;
    endcase
  endfunction

  // activity clears idle time and wakes a sleeping state with two words
  function automatic int wake_up(input logic pop);
    idle_time = '0;
    if (power_now == ipsc_pkg::PS_IDLE || power_now == ipsc_pkg::PS_LOW) begin
      pred_words[0] = state_word(ipsc_pkg::PS_WAKE, ipsc_pkg::GOV_PERF, 1'b1, pop);
      pred_words[1] = state_word(ipsc_pkg::PS_RUN, ipsc_pkg::GOV_NONE, 1'b1, 1'b0);
      power_now = ipsc_pkg::PS_RUN;
      return 2;
    end
    return 0;
  endfunction

  // expected result words for one event word
  function automatic int power_step(input logic m, input logic rx);
    int         n;
    logic [1:0] goal;
    logic [1:0] gov;
    n = 0;
    if (m == MODE_KEY) begin
      if (key_age >= debounce_len) begin
        key_age = '0;
        n = wake_up(1'b0);
      end
    end else begin
      if (idle_time != 16'hFFFF) idle_time++;
      if (key_age != 10'h3FF) key_age++;
      if (int'(period_pos) + 1 < int'(period_len)) begin
        period_pos++;
        return 0;
      end
      period_pos = '0;
      if (rx) n = wake_up(1'b1);
      if (idle_time > lim_low) goal = ipsc_pkg::PS_LOW;
      else if (idle_time > lim_idle) goal = ipsc_pkg::PS_IDLE;
      else goal = ipsc_pkg::PS_RUN;
      if (goal != power_now) begin
        if (goal == ipsc_pkg::PS_LOW) gov = ipsc_pkg::GOV_ONDEMAND;
        else if (goal == ipsc_pkg::PS_RUN) gov = ipsc_pkg::GOV_PERF;
        else gov = ipsc_pkg::GOV_NONE;
        power_now = goal;
        pred_words[n] = state_word(goal, gov, 1'b1, (n == 0) ? rx : 1'b0);
        n++;
      end else if (n == 0) begin
        pred_words[0] = state_word(power_now, ipsc_pkg::GOV_NONE, 1'b0, rx);
        n = 1;
      end
    end
    if (n > 0) pred_words[n-1].last = 1'b1;
    return n;
  endfunction

  // track accepted words and check results, all on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      lim_idle     = ipsc_pkg::RST_IDLE_AFTER;
      lim_low      = ipsc_pkg::RST_LOW_AFTER;
      debounce_len = ipsc_pkg::RST_DEBOUNCE;
      period_len   = ipsc_pkg::RST_PERIOD;
      led_run      = ipsc_pkg::RST_RUN_LED;
      led_idle     = ipsc_pkg::RST_IDLE_LED;
      led_low      = ipsc_pkg::RST_LOW_LED;
      idle_time    = '0;
      key_age      = '1;
      period_pos   = '0;
      power_now    = ipsc_pkg::PS_RUN;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) set_register(paddr[4:2], pwdata);
      if (in_ch.valid && in_ch.ready) begin
        produced = power_step(in_ch.mode, in_ch.rx_nonempty);
        if (typed_n >= 0) begin
          if (typed_n > 0) expected_words.push_back(typed_w0);
          if (typed_n > 1) expected_words.push_back(typed_w1);
        end else begin
          for (int k = 0; k < produced; k++) expected_words.push_back(pred_words[k]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got.power_state     = out_ch.power_state;
        got.led_percent     = out_ch.led_percent;
        got.led_on          = out_ch.led_on;
        got.governor_action = out_ch.governor_action;
        got.announce        = out_ch.announce;
        got.rx_pop          = out_ch.rx_pop;
        got.last            = out_ch.last;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word at %0t: st=%0d pct=%0d on=%0b gov=%0d",
                     $realtime, got.power_state, got.led_percent, got.led_on,
                     got.governor_action);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("result mismatch at %0t: expected st=%0d pct=%0d on=%0b gov=%0d ann=%0b pop=%0b last=%0b",
                       $realtime, want.power_state, want.led_percent, want.led_on,
                       want.governor_action, want.announce, want.rx_pop, want.last);
              $display("  actual st=%0d pct=%0d on=%0b gov=%0d ann=%0b pop=%0b last=%0b",
                       got.power_state, got.led_percent, got.led_on,
                       got.governor_action, got.announce, got.rx_pop, got.last);
            end
          end
        end
      end
    end
  end

  // result receiver: random stalls plus requested long hold-offs
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(out_idle_en && $urandom_range(99) < 6);
      end
    end
  end

  function automatic void plan_event(input logic m, input logic rx);
    plan_row_t row;
    row.kind = ROW_EVENT; row.idx = '0; row.data = '0;
    row.m = m; row.rx = rx; row.n_typed = -1; row.w0 = '0; row.w1 = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_typed(input logic m, input logic rx, input int n,
                                     input ipsc_pkg::result_t w0,
                                     input ipsc_pkg::result_t w1);
    plan_row_t row;
    row.kind = ROW_EVENT; row.idx = '0; row.data = '0;
    row.m = m; row.rx = rx; row.n_typed = n; row.w0 = w0; row.w1 = w1;
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_write(input logic [2:0] idx, input logic [31:0] v);
    plan_row_t row;
    row.kind = ROW_WRITE; row.idx = idx; row.data = v;
    row.m = MODE_TICK; row.rx = 1'b0; row.n_typed = -1; row.w0 = '0; row.w1 = '0;
    directed_rows.push_back(row);
  endfunction

  // random register value, biased to small thresholds with the odd extreme
  function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
    int roll;
    roll = $urandom_range(99);
    case (idx)
      ipsc_pkg::REG_IDLE_AFTER, ipsc_pkg::REG_LOW_AFTER: begin
        if (roll < 5) return 32'd0;
        if (roll < 10) return 32'd65535;
        return (idx == ipsc_pkg::REG_IDLE_AFTER) ? $urandom_range(40) : $urandom_range(80);
      end
      ipsc_pkg::REG_DEBOUNCE: begin
        if (roll < 5) return 32'd0;
        if (roll < 10) return 32'd1023;
        return $urandom_range(30);
      end
      ipsc_pkg::REG_PERIOD: begin
        if (roll < 5) return 32'd0;
        if (roll < 8) return 32'd4095;
        return $urandom_range(1, 10);
      end
      default: return $urandom_range(127);
    endcase
  endfunction

  task automatic send_word(input logic m, input logic rx, input int n_typed,
                           input ipsc_pkg::result_t w0, input ipsc_pkg::result_t w1);
    @(negedge clk);
    while (in_idle_en && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_n  = n_typed;
    typed_w0 = w0;
    typed_w1 = w1;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.rx_nonempty <= rx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int key_pct;
    int rx_pct;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_TICK;
    in_ch.rx_nonempty = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    typed_n  = -1;
    typed_w0 = '0;
    typed_w1 = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table: reset key, fast checks, wakeups, led off and clamp, zero period
    plan_typed(MODE_KEY, 1'b0, 0, '0, '0);
    plan_write(ipsc_pkg::REG_PERIOD, 32'd1);
    plan_write(ipsc_pkg::REG_IDLE_AFTER, 32'd0);
    plan_write(ipsc_pkg::REG_LOW_AFTER, 32'd2);
    plan_typed(MODE_TICK, 1'b0, 1,
               pack_word(ipsc_pkg::PS_IDLE, ipsc_pkg::RST_IDLE_LED, ipsc_pkg::GOV_NONE,
                         1'b1, 1'b0, 1'b1), '0);
    plan_typed(MODE_TICK, 1'b0, 1,
               pack_word(ipsc_pkg::PS_IDLE, ipsc_pkg::RST_IDLE_LED, ipsc_pkg::GOV_NONE,
                         1'b0, 1'b0, 1'b1), '0);
    plan_typed(MODE_TICK, 1'b0, 1,
               pack_word(ipsc_pkg::PS_LOW, ipsc_pkg::RST_LOW_LED, ipsc_pkg::GOV_ONDEMAND,
                         1'b1, 1'b0, 1'b1), '0);
    plan_typed(MODE_TICK, 1'b1, 2,
               pack_word(ipsc_pkg::PS_WAKE, ipsc_pkg::RST_RUN_LED, ipsc_pkg::GOV_PERF,
                         1'b1, 1'b1, 1'b0),
               pack_word(ipsc_pkg::PS_RUN, ipsc_pkg::RST_RUN_LED, ipsc_pkg::GOV_NONE,
                         1'b1, 1'b0, 1'b1));
    plan_typed(MODE_KEY, 1'b1, 0, '0, '0);
    plan_write(ipsc_pkg::REG_DEBOUNCE, 32'd0);
    plan_event(MODE_KEY, 1'b0);
    plan_typed(MODE_TICK, 1'b1, 1,
               pack_word(ipsc_pkg::PS_RUN, ipsc_pkg::RST_RUN_LED, ipsc_pkg::GOV_NONE,
                         1'b0, 1'b1, 1'b1), '0);
    plan_write(ipsc_pkg::REG_RUN_LED, 32'd0);
    plan_write(ipsc_pkg::REG_IDLE_LED, 32'd127);
    plan_write(ipsc_pkg::REG_LOW_LED, 32'd101);
    plan_typed(MODE_TICK, 1'b0, 1,
               pack_word(ipsc_pkg::PS_IDLE, ipsc_pkg::PCT_MAX, ipsc_pkg::GOV_NONE,
                         1'b1, 1'b0, 1'b1), '0);
    plan_typed(MODE_KEY, 1'b0, 2,
               pack_word(ipsc_pkg::PS_WAKE, 7'd0, ipsc_pkg::GOV_PERF, 1'b1, 1'b0, 1'b0),
               pack_word(ipsc_pkg::PS_RUN, 7'd0, ipsc_pkg::GOV_NONE, 1'b1, 1'b0, 1'b1));
    plan_write(ipsc_pkg::REG_PERIOD, 32'd0);
    plan_event(MODE_TICK, 1'b0);
    plan_event(MODE_TICK, 1'b0);
    plan_event(MODE_TICK, 1'b0);
    plan_write(ipsc_pkg::REG_DEBOUNCE, 32'd1023);
    plan_write(ipsc_pkg::REG_IDLE_AFTER, 32'd65535);
    plan_write(ipsc_pkg::REG_LOW_AFTER, 32'd65535);
    plan_event(MODE_KEY, 1'b0);
    plan_event(MODE_TICK, 1'b1);
    plan_event(MODE_TICK, 1'b0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_until_drained();
        write_register(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_word(directed_rows[r].m, directed_rows[r].rx, directed_rows[r].n_typed,
                  directed_rows[r].w0, directed_rows[r].w1);
      end
    end

    // receiver holds off while a result comes back for every tick
    wait_until_drained();
    write_register(ipsc_pkg::REG_PERIOD, 32'd1);
    write_register(ipsc_pkg::REG_IDLE_AFTER, 32'd0);
    write_register(ipsc_pkg::REG_LOW_AFTER, 32'd3);
    write_register(ipsc_pkg::REG_DEBOUNCE, 32'd2);
    hold_asked++;
    for (int i = 0; i < 40; i++)
      send_word(MODE_TICK, ($urandom_range(99) < 30), -1, '0, '0);
    wait_until_drained();

    // random phases, each with fresh register settings
    for (int p = 0; p < PHASES; p++) begin
      wait_until_drained();
      in_idle_en  = (p != 4);
      out_idle_en = (p != 4);
      for (int i = int'(ipsc_pkg::REG_IDLE_AFTER); i <= int'(ipsc_pkg::REG_LOW_LED); i++)
        write_register(3'(i), pick_reg_value(3'(i)));
      key_pct = $urandom_range(2, 15);
      rx_pct  = $urandom_range(1, 10);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word(($urandom_range(99) < key_pct) ? MODE_KEY : MODE_TICK,
                  ($urandom_range(99) < rx_pct), -1, '0, '0);
    end

    wait_until_drained();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
